// ===== hdl/qcs_pkg.sv =====
`timescale 1ns / 1ps

package qcs_pkg;

    // Channel count, channel field width and the values derived from them
    localparam int NUM_CHANNELS = 4;
    localparam int CHAN_W       = 3;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W + 1)'(NUM_CHANNELS);
    localparam logic [CH_W-1:0] LAST_CH    = CH_W'(NUM_CHANNELS - 1);

    // Data widths
    localparam int DATA_W   = 32;
    localparam int PERIOD_W = 16;
    localparam int MULT_W   = 16;
    localparam int PROD_W   = DATA_W + MULT_W;
    localparam int DIV_CNT_W = $clog2(PROD_W + 1);

    localparam logic [MULT_W-1:0]   MS_PER_MINUTE = 16'd60000;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 16'd100;

    // Request codes
    typedef enum logic [1:0] {
        REQ_EDGE   = 2'd0,
        REQ_SAMPLE = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_EDGE,
        ST_CLEAR,
        ST_CHECK,
        ST_ABS,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic apply_edge;
        logic apply_clear;
        logic check;
        logic abs_load;
        logic mul_load;
        logic div_start;
        logic emit_sample;
        logic idx_clear;
        logic idx_next;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] req;
        logic       chan_ok;
        logic       due;
        logic       div_busy;
        logic       slot_free;
        logic       idx_last;
    } dp_status_t;

endpackage

// ===== hdl/qcs_divider.sv =====
`timescale 1ns / 1ps

module qcs_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [qcs_pkg::PROD_W-1:0]    dividend,
    input  logic [qcs_pkg::DATA_W-1:0]    divisor,
    output logic                          busy,
    output logic [qcs_pkg::PROD_W-1:0]    quotient
);
    import qcs_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [PROD_W-1:0]    quo_reg, quo_next;
    logic [DATA_W-1:0]    dvs_reg, dvs_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      diff;
    logic                 ge;

    // One restoring step per cycle: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[PROD_W-1]};
        ge       = (shifted >= {1'b0, dvs_reg});
        diff     = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(PROD_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/qcs_datapath.sv =====
`timescale 1ns / 1ps

module qcs_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  qcs_pkg::dp_cmd_t                   cmd,
    output qcs_pkg::dp_status_t                status,
    input  logic                               cfg_wr_en,
    input  logic [qcs_pkg::PERIOD_W-1:0]       cfg_wr_data,
    input  logic [1:0]                         req_type,
    input  logic [qcs_pkg::CHAN_W-1:0]         channel,
    input  logic                               phase_a_level,
    input  logic                               phase_b_level,
    input  logic [qcs_pkg::DATA_W-1:0]         now_ms,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [qcs_pkg::CHAN_W-1:0]         result_channel,
    output logic signed [qcs_pkg::DATA_W-1:0]  count_value,
    output logic signed [qcs_pkg::DATA_W-1:0]  speed_value,
    output logic                               speed_updated,
    output logic                               last_of_run
);
    import qcs_pkg::*;

    // Channel state
    logic [DATA_W-1:0] count_reg  [NUM_CHANNELS];
    logic [DATA_W-1:0] snap_reg   [NUM_CHANNELS];
    logic [DATA_W-1:0] stamp_reg  [NUM_CHANNELS];
    logic [DATA_W-1:0] speed_reg  [NUM_CHANNELS];

    logic [PERIOD_W-1:0] period_reg;

    // Captured item
    logic [1:0]        req_reg;
    logic [CHAN_W-1:0] chan_reg;
    logic              a_reg;
    logic              b_reg;
    logic [DATA_W-1:0] now_reg;
    logic [CH_W-1:0]   idx_reg;

    // Speed pipeline
    logic [DATA_W-1:0] delta_reg;
    logic [DATA_W-1:0] dt_reg;
    logic              due_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] mag_reg;
    logic [PROD_W-1:0] prod_reg;

    // Output register
    logic              out_valid_reg;
    logic [CHAN_W-1:0] out_chan_reg;
    logic [DATA_W-1:0] out_count_reg;
    logic [DATA_W-1:0] out_speed_reg;
    logic              out_upd_reg;
    logic              out_last_reg;

    logic [CH_W-1:0]   ch_idx;
    logic [DATA_W-1:0] edge_count;
    logic [DATA_W-1:0] dt_now;
    logic [DATA_W-1:0] period_ext;
    logic              due_now;
    logic              div_busy;
    logic [PROD_W-1:0] quotient;
    logic [DATA_W-1:0] speed_new;
    logic              slot_free;
    logic              load_out;

    assign ch_idx     = chan_reg[CH_W-1:0];
    assign edge_count = (a_reg == b_reg) ? (count_reg[ch_idx] - 1'b1)
                                         : (count_reg[ch_idx] + 1'b1);
    assign period_ext = (period_reg == '0) ? DATA_W'(1) : DATA_W'(period_reg);
    assign dt_now     = now_reg - stamp_reg[idx_reg];
    assign due_now    = (dt_now >= period_ext);
    assign slot_free  = !out_valid_reg || out_ready;
    assign load_out   = cmd.apply_edge || cmd.apply_clear || cmd.emit_sample;

    // Saturate the signed quotient to 32 bits
    always_comb
    begin
        if (!neg_reg)
        begin
            if (quotient > PROD_W'(32'h7FFF_FFFF))
                speed_new = 32'h7FFF_FFFF;
            else
                speed_new = quotient[DATA_W-1:0];
        end
        else
        begin
            if (quotient > PROD_W'(33'h0_8000_0000))
                speed_new = 32'h8000_0000;
            else
                speed_new = -quotient[DATA_W-1:0];
        end
    end

    qcs_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (dt_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_comb
    begin
        status.req       = req_reg;
        status.chan_ok   = ({1'b0, chan_reg} < CHAN_LIMIT);
        status.due       = due_now;
        status.div_busy  = div_busy;
        status.slot_free = slot_free;
        status.idx_last  = (idx_reg == LAST_CH);
    end

    // Channel state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                count_reg[i] <= '0;
                snap_reg[i]  <= '0;
                stamp_reg[i] <= '0;
                speed_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
                period_reg <= cfg_wr_data;
            if (cmd.apply_edge)
                count_reg[ch_idx] <= edge_count;
            if (cmd.apply_clear)
            begin
                count_reg[ch_idx] <= '0;
                snap_reg[ch_idx]  <= '0;
            end
            if (cmd.emit_sample && due_reg)
            begin
                speed_reg[idx_reg] <= speed_new;
                snap_reg[idx_reg]  <= count_reg[idx_reg];
                stamp_reg[idx_reg] <= now_reg;
            end
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Index of the channel being sampled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (cmd.idx_clear)
            idx_reg <= '0;
        else if (cmd.idx_next)
            idx_reg <= idx_reg + 1'b1;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req_type;
            chan_reg <= channel;
            a_reg    <= phase_a_level;
            b_reg    <= phase_b_level;
            now_reg  <= now_ms;
        end
        if (cmd.check)
        begin
            delta_reg <= count_reg[idx_reg] - snap_reg[idx_reg];
            dt_reg    <= dt_now;
            due_reg   <= due_now;
        end
        if (cmd.abs_load)
        begin
            neg_reg <= delta_reg[DATA_W-1];
            mag_reg <= delta_reg[DATA_W-1] ? -delta_reg : delta_reg;
        end
        if (cmd.mul_load)
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(MS_PER_MINUTE);
        if (cmd.apply_edge)
        begin
            out_chan_reg  <= chan_reg;
            out_count_reg <= edge_count;
            out_speed_reg <= speed_reg[ch_idx];
            out_upd_reg   <= 1'b0;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.apply_clear)
        begin
            out_chan_reg  <= chan_reg;
            out_count_reg <= '0;
            out_speed_reg <= speed_reg[ch_idx];
            out_upd_reg   <= 1'b0;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.emit_sample)
        begin
            out_chan_reg  <= CHAN_W'(idx_reg);
            out_count_reg <= count_reg[idx_reg];
            out_speed_reg <= due_reg ? speed_new : speed_reg[idx_reg];
            out_upd_reg   <= due_reg;
            out_last_reg  <= (idx_reg == LAST_CH);
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_channel = out_chan_reg;
    assign count_value    = out_count_reg;
    assign speed_value    = out_speed_reg;
    assign speed_updated  = out_upd_reg;
    assign last_of_run    = out_last_reg;

endmodule

// ===== hdl/qcs_ctrl.sv =====
`timescale 1ns / 1ps

module qcs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  qcs_pkg::dp_status_t  status,
    output qcs_pkg::dp_cmd_t     cmd
);
    import qcs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (status.req)
                    REQ_EDGE:   state_next = status.chan_ok ? ST_EDGE : ST_IDLE;
                    REQ_CLEAR:  state_next = status.chan_ok ? ST_CLEAR : ST_IDLE;
                    REQ_SAMPLE:
                    begin
                        cmd.idx_clear = 1'b1;
                        state_next    = ST_CHECK;
                    end
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_EDGE:
            begin
                if (status.slot_free)
                begin
                    cmd.apply_edge = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (status.slot_free)
                begin
                    cmd.apply_clear = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = status.due ? ST_ABS : ST_EMIT;
            end
            ST_ABS:
            begin
                cmd.abs_load = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_START;
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.slot_free)
                begin
                    cmd.emit_sample = 1'b1;
                    if (status.idx_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        cmd.idx_next = 1'b1;
                        state_next   = ST_CHECK;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/quadrature_counter_with_speed.sv =====
`timescale 1ns / 1ps
// Edge and clear items: captured, dispatched and loaded into the output register once it is free;
// an item whose channel is out of range gives no output. Sample items: each channel is checked,
// and a due one goes through magnitude, multiply and the 48 steps of the shared one-bit-per-cycle
// divider; back-pressure holds each emit. One item at a time: the next is taken only in idle.
// Reset (rst_n, asynchronous, active low): counts, snapshots, time stamps and speeds zero,
// sample period 100 ms, output empty, controller idle.

module quadrature_counter_with_speed (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration: sample period in ms
    input  logic                               cfg_wr_en,
    input  logic [qcs_pkg::PERIOD_W-1:0]       cfg_wr_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         req_type,
    input  logic [qcs_pkg::CHAN_W-1:0]         channel,
    input  logic                               phase_a_level,
    input  logic                               phase_b_level,
    input  logic [qcs_pkg::DATA_W-1:0]         now_ms,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [qcs_pkg::CHAN_W-1:0]         result_channel,
    output logic signed [qcs_pkg::DATA_W-1:0]  count_value,
    output logic signed [qcs_pkg::DATA_W-1:0]  speed_value,
    output logic                               speed_updated,
    output logic                               last_of_run
);
    import qcs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Controller: takes one transfer, sequences edge/clear updates or walks the
    // channels for a sample, and holds while the output register is full and out_ready is low.
    qcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: per-channel state, speed pipeline (delta, magnitude, multiply by
    // 60000, divide by elapsed ms, saturate) and the output register, which lets
    // a finished result wait while the next item is taken in.
    qcs_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .req_type       (req_type),
        .channel        (channel),
        .phase_a_level  (phase_a_level),
        .phase_b_level  (phase_b_level),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_channel (result_channel),
        .count_value    (count_value),
        .speed_value    (speed_value),
        .speed_updated  (speed_updated),
        .last_of_run    (last_of_run)
    );

endmodule
